/* hw/rtl/fwds_pkg.sv */
// Shared types and constants for the filter wheel dwell sequencer.
// No dependencies.
package fwds_pkg;

    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int SLOT_W     = 3;
    localparam int POS_W      = 4;
    localparam int TICK_W     = 16;
    localparam int KIND_W     = 2;
    localparam int ADV_W      = 4;

    localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MANUAL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GO_AROUND    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 2'd3;

    localparam logic signed [POS_W-1:0] POS_NONE = -4'sd1;
    localparam logic [TICK_W-1:0]       TICK_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic search_req;
        logic search_done;
    } dp_status_t;

endpackage

/* hw/rtl/fwds_ctrl.sv */
// Controller for the filter wheel dwell sequencer: item handshake, search
// sequencing and output word valid. Depends on fwds_pkg.
module fwds_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  fwds_pkg::dp_status_t status,
    output fwds_pkg::ctrl_cmd_t  cmd
);
    import fwds_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.search_req ? ST_SEARCH : ST_COMMIT;
                end
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

/* hw/rtl/fwds_dp.sv */
// Datapath for the filter wheel dwell sequencer: configuration, wheel state,
// dwell slot search step and output word. Depends on fwds_pkg.
module fwds_dp #(
    parameter int MAX_SLOTS  = 6,
    parameter int DWELL_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fwds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fwds_pkg::CFG_W-1:0]           cfg_data,
    input  logic [fwds_pkg::KIND_W-1:0]          kind,
    input  logic                                 frame_valid,
    input  logic signed [fwds_pkg::POS_W-1:0]    reported_slot,
    input  logic [fwds_pkg::SLOT_W-1:0]          manual_target,
    output logic signed [fwds_pkg::POS_W-1:0]    wheel_slot,
    output logic [fwds_pkg::SLOT_W-1:0]          target_slot,
    output logic                                 move_issued,
    output logic                                 no_valid_setting,
    input  fwds_pkg::ctrl_cmd_t                  cmd,
    output fwds_pkg::dp_status_t                 status
);
    import fwds_pkg::*;

    localparam int SLOTS_CMP_W = 5;
    localparam int SHIFT_W     = 8;

    // configuration
    logic [CFG_W-1:0]  dwell_table_reg;
    logic [2:0]        slots_in_use_reg;
    logic              go_around_reg;
    logic [TICK_W-1:0] settle_ticks_reg;

    // wheel state
    logic [SLOT_W-1:0]       next_slot_reg,      next_slot_next;
    logic [DWELL_BITS-1:0]   dwell_position_reg, dwell_position_next;
    logic signed [POS_W-1:0] commanded_reg,      commanded_next;
    logic signed [POS_W-1:0] current_reg,        current_next;
    logic [SLOT_W-1:0]       target_reg,         target_next;
    logic [TICK_W-1:0]       elapsed_reg,        elapsed_next;
    logic                    moved_next;

    // latched item
    logic [KIND_W-1:0]       kind_reg;
    logic signed [POS_W-1:0] rep_reg;
    logic [SLOT_W-1:0]       man_reg;
    logic                    item_search_reg;

    // search
    logic [SLOT_W-1:0]     idx_reg;
    logic [DWELL_BITS:0]   d_reg;
    logic [ADV_W-1:0]      adv_reg;
    logic                  done_reg;
    logic                  fail_reg;

    // output word
    logic signed [POS_W-1:0] wheel_slot_reg;
    logic [SLOT_W-1:0]       target_slot_reg;
    logic                    move_issued_reg;
    logic                    no_valid_reg;

    logic [SLOTS_CMP_W-1:0] slots_wide;
    logic [SLOTS_CMP_W-1:0] n_wide;
    logic [SLOT_W-1:0]      n;
    logic [SHIFT_W-1:0]     dwell_shift;
    logic [CFG_W-1:0]       dwell_shifted;
    logic [DWELL_BITS-1:0]  dwell_cur;
    logic                   hit;
    logic [SLOT_W:0]        idx_inc;
    logic [SLOT_W-1:0]      idx_wrap;
    logic [ADV_W-1:0]       adv_inc;
    logic                   wrap_fail;
    logic signed [POS_W-1:0] pos;

    assign slots_wide = {2'b00, slots_in_use_reg};
    assign n_wide = (slots_wide == '0) ? SLOTS_CMP_W'(1) :
                    (slots_wide > SLOTS_CMP_W'(MAX_SLOTS)) ? SLOTS_CMP_W'(MAX_SLOTS) :
                    slots_wide;
    assign n = n_wide[SLOT_W-1:0];

    assign dwell_shift   = SHIFT_W'(idx_reg) * SHIFT_W'(DWELL_BITS);
    assign dwell_shifted = dwell_table_reg >> dwell_shift;
    assign dwell_cur = ({2'b00, idx_reg} < SLOTS_CMP_W'(MAX_SLOTS)) ?
                       dwell_shifted[DWELL_BITS-1:0] : '0;

    assign hit       = d_reg < {1'b0, dwell_cur};
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign idx_wrap  = (idx_inc >= {1'b0, n}) ? '0 : idx_inc[SLOT_W-1:0];
    assign adv_inc   = adv_reg + 1'b1;
    assign wrap_fail = (idx_wrap == next_slot_reg) || (adv_inc > {1'b0, n});

    assign status.search_req  = (kind == KIND_FRAME) && frame_valid && go_around_reg;
    assign status.search_done = done_reg;

    assign wheel_slot       = wheel_slot_reg;
    assign target_slot      = target_slot_reg;
    assign move_issued      = move_issued_reg;
    assign no_valid_setting = no_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_table_reg  <= '0;
            slots_in_use_reg <= 3'd6;
            go_around_reg    <= 1'b0;
            settle_ticks_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DWELL_TABLE:  dwell_table_reg  <= cfg_data;
                REG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[2:0];
                REG_GO_AROUND:    go_around_reg    <= cfg_data[0];
                REG_SETTLE_TICKS: settle_ticks_reg <= cfg_data[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg        <= kind;
            rep_reg         <= reported_slot;
            man_reg         <= manual_target;
            item_search_reg <= status.search_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            d_reg    <= '0;
            adv_reg  <= '0;
            done_reg <= 1'b0;
            fail_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg  <= next_slot_reg;
            d_reg    <= {1'b0, dwell_position_reg} + 1'b1;
            adv_reg  <= '0;
            done_reg <= 1'b0;
            fail_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (hit)
            begin
                done_reg <= 1'b1;
            end
            else
            begin
                d_reg   <= '0;
                idx_reg <= idx_wrap;
                adv_reg <= adv_inc;
                if (wrap_fail)
                begin
                    done_reg <= 1'b1;
                    fail_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        next_slot_next      = next_slot_reg;
        dwell_position_next = dwell_position_reg;
        commanded_next      = commanded_reg;
        current_next        = current_reg;
        target_next         = target_reg;
        elapsed_next        = elapsed_reg;
        moved_next          = 1'b0;
        pos                 = rep_reg;

        case (kind_reg)
            KIND_FRAME:
            begin
                if (item_search_reg && !fail_reg)
                begin
                    dwell_position_next = d_reg[DWELL_BITS-1:0];
                    next_slot_next      = idx_reg;
                    if (idx_reg != target_reg)
                    begin
                        elapsed_next   = '0;
                        current_next   = POS_NONE;
                        commanded_next = {1'b0, idx_reg};
                        target_next    = idx_reg;
                        moved_next     = 1'b1;
                    end
                end
            end
            KIND_REPORT:
            begin
                if (rep_reg[POS_W-1])
                begin
                    pos = POS_NONE;
                end
                else if (!commanded_reg[POS_W-1] && (rep_reg != commanded_reg))
                begin
                    pos = POS_NONE;
                end
                if (!pos[POS_W-1])
                begin
                    current_next = (elapsed_reg < settle_ticks_reg) ? POS_NONE : pos;
                end
                else
                begin
                    current_next = POS_NONE;
                    elapsed_next = '0;
                end
            end
            KIND_TICK:
            begin
                if (elapsed_reg != TICK_MAX)
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            KIND_MANUAL:
            begin
                if (man_reg < n)
                begin
                    target_next = man_reg;
                    if (commanded_reg != {1'b0, man_reg})
                    begin
                        commanded_next      = {1'b0, man_reg};
                        current_next        = POS_NONE;
                        elapsed_next        = '0;
                        next_slot_next      = man_reg;
                        dwell_position_next = '0;
                        moved_next          = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_slot_reg      <= '0;
            dwell_position_reg <= '0;
            commanded_reg      <= POS_NONE;
            current_reg        <= POS_NONE;
            target_reg         <= '0;
            elapsed_reg        <= '0;
        end
        else if (cmd.commit)
        begin
            next_slot_reg      <= next_slot_next;
            dwell_position_reg <= dwell_position_next;
            commanded_reg      <= commanded_next;
            current_reg        <= current_next;
            target_reg         <= target_next;
            elapsed_reg        <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            wheel_slot_reg  <= current_next;
            target_slot_reg <= target_next;
            move_issued_reg <= moved_next;
            no_valid_reg    <= (kind_reg == KIND_FRAME) && item_search_reg && fail_reg;
        end
    end

endmodule

/* hw/rtl/filter_wheel_dwell_sequencer.sv */
// Filter wheel dwell sequencer with settle qualification, top level.
// Instantiates fwds_ctrl and fwds_dp; depends on fwds_pkg.
//
// One result word per input word. A word that needs no slot search (tick,
// position report, manual target, or a frame that is invalid or arrives with
// go-around off) goes straight to the commit state, which registers the
// result once the output register is free. A frame that searches examines one
// slot per search step, at most the effective slot count plus one, then goes
// to the commit state to register the result. The next input word is taken the
// cycle after the result is registered, even while that result still waits on
// out_stall; the following result then holds until the output register frees.
module filter_wheel_dwell_sequencer #(
    parameter int MAX_SLOTS  = 6,
    parameter int DWELL_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fwds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fwds_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [fwds_pkg::KIND_W-1:0]          kind,
    input  logic                                 frame_valid,
    input  logic signed [fwds_pkg::POS_W-1:0]    reported_slot,
    input  logic [fwds_pkg::SLOT_W-1:0]          manual_target,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [fwds_pkg::POS_W-1:0]    wheel_slot,
    output logic [fwds_pkg::SLOT_W-1:0]          target_slot,
    output logic                                 move_issued,
    output logic                                 no_valid_setting
);
    import fwds_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fwds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fwds_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .DWELL_BITS (DWELL_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .kind             (kind),
        .frame_valid      (frame_valid),
        .reported_slot    (reported_slot),
        .manual_target    (manual_target),
        .wheel_slot       (wheel_slot),
        .target_slot      (target_slot),
        .move_issued      (move_issued),
        .no_valid_setting (no_valid_setting),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
